/* src/bwlcd_pkg.sv */
// shared types and constants for the bitmap window lcd bus writer
// no dependencies; the unit, front end, queue and sequencer refer to it by scoped names
package bwlcd_pkg;

  localparam int PIXELS_PER_BYTE = 8;
  localparam int CFG_IDX_W       = 2;

  typedef enum logic [1:0] {
    KIND_OPEN   = 2'd0,
    KIND_BITMAP = 2'd1,
    KIND_SOLID  = 2'd2
  } kind_e;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COL_CMD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_CMD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_CMD  = 2'd2;

  localparam logic [7:0] COL_CMD_RESET  = 8'd42;
  localparam logic [7:0] PAGE_CMD_RESET = 8'd43;
  localparam logic [7:0] MEM_CMD_RESET  = 8'd44;

  localparam logic [7:0] SOLID_BITS = 8'hFF;

  // byte positions of the window command sequence
  localparam logic [3:0] STEP_COL_CMD  = 4'd0;
  localparam logic [3:0] STEP_X0_HI    = 4'd1;
  localparam logic [3:0] STEP_X0_LO    = 4'd2;
  localparam logic [3:0] STEP_X1_HI    = 4'd3;
  localparam logic [3:0] STEP_X1_LO    = 4'd4;
  localparam logic [3:0] STEP_PAGE_CMD = 4'd5;
  localparam logic [3:0] STEP_Y0_HI    = 4'd6;
  localparam logic [3:0] STEP_Y0_LO    = 4'd7;
  localparam logic [3:0] STEP_Y1_HI    = 4'd8;
  localparam logic [3:0] STEP_Y1_LO    = 4'd9;
  localparam logic [3:0] STEP_MEM_CMD  = 4'd10;

  typedef struct packed {
    logic [7:0] col_cmd;
    logic [7:0] page_cmd;
    logic [7:0] mem_cmd;
  } cfg_t;

  // one unit of work for the bus side
  typedef struct packed {
    logic        is_window;
    logic [15:0] x0;
    logic [15:0] x1;
    logic [15:0] y0;
    logic [15:0] y1;
    logic [15:0] fore;
    logic [15:0] back;
    logic [7:0]  bits;
    logic [2:0]  cnt_m1;
  } job_t;

endpackage

/* src/bwlcd_in_if.sv */
// input item channel: valid, ready and the item fields
// depends on nothing
interface bwlcd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] x_pos;
  logic [15:0] y_pos;
  logic [15:0] win_width;
  logic [15:0] win_height;
  logic        centred;
  logic [15:0] fore_colour;
  logic [15:0] back_colour;
  logic [7:0]  bitmap_byte;

  modport source (output valid, kind, x_pos, y_pos, win_width, win_height, centred,
                  fore_colour, back_colour, bitmap_byte, input ready);
  modport sink (input valid, kind, x_pos, y_pos, win_width, win_height, centred,
                fore_colour, back_colour, bitmap_byte, output ready);
endinterface

/* src/bwlcd_out_if.sv */
// bus byte channel: valid, ready and one bus byte with its strobes
// depends on nothing
interface bwlcd_out_if;
  logic       valid;
  logic       ready;
  logic       is_command;
  logic [7:0] bus_byte;
  logic       end_of_select;
  logic       last;

  modport source (output valid, is_command, bus_byte, end_of_select, last, input ready);
  modport sink (input valid, is_command, bus_byte, end_of_select, last, output ready);
endinterface

/* src/bitmap_window_to_lcd_bus_writer_unit.sv */
// an accepted item passes through the job queue, the sequencer's job register and the output register
// before its first bus byte is valid; the sequencer gives one bus byte per cycle while out_ch is ready;
//   an open item gives 11 bytes, a bitmap or solid item two per pixel (up to 16), an item with no room none
// items are taken while the job queue has room, so the front runs ahead of the bus side
// reset: asynchronous active low; window size, counters and colours clear to zero,
//   command registers return to 42, 43 and 44, queue and output register empty
module bitmap_window_to_lcd_bus_writer_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  bwlcd_in_if.sink                       in_ch,
  bwlcd_out_if.source                    out_ch,
  input  logic                           cfg_we_i,
  input  logic [bwlcd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]                     cfg_data_i
);

  bwlcd_pkg::cfg_t cfg_q;
  logic            push, q_ready, q_valid, pop;
  bwlcd_pkg::job_t push_job, q_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.col_cmd  <= bwlcd_pkg::COL_CMD_RESET;
      cfg_q.page_cmd <= bwlcd_pkg::PAGE_CMD_RESET;
      cfg_q.mem_cmd  <= bwlcd_pkg::MEM_CMD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bwlcd_pkg::CFG_COL_CMD:  cfg_q.col_cmd  <= cfg_data_i;
        bwlcd_pkg::CFG_PAGE_CMD: cfg_q.page_cmd <= cfg_data_i;
        bwlcd_pkg::CFG_MEM_CMD:  cfg_q.mem_cmd  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  bwlcd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .q_ready_i (q_ready),
    .push_o    (push),
    .job_o     (push_job)
  );

  bwlcd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (q_job)
  );

  bwlcd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_job_i   (q_job),
    .pop_o     (pop),
    .out_ch    (out_ch)
  );

`ifndef ASSERT_OFF
  // the sequencer never takes a job from an empty queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("job popped from empty queue");

  // every command byte releases chip select
  a_cmd_eos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.is_command) |-> out_ch.end_of_select)
    else $error("command byte without chip select release");

  // an item's final byte is always a command or the low byte of a pixel
  a_last_eos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.last) |-> out_ch.end_of_select)
    else $error("final byte of item keeps chip select");

  // after an accepted push the queue output is valid on the next cycle
  a_push_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && q_ready) |=> q_valid)
    else $error("pushed job missing from queue");
`endif

endmodule

/* src/bwlcd_front.sv */
// front end: accepts items, keeps window and pixel position state, emits jobs
// depends on bwlcd_pkg and bwlcd_in_if
module bwlcd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  bwlcd_in_if.sink         in_ch,
  input  logic             q_ready_i,
  output logic             push_o,
  output bwlcd_pkg::job_t  job_o
);

  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic [15:0] row_q, row_d;
  logic [15:0] col_q, col_d;
  logic [15:0] fore_q, fore_d;
  logic [15:0] back_q, back_d;

  logic        accept;
  logic        has_room;
  logic [15:0] remain;
  logic [3:0]  count;
  logic [15:0] col_sum;
  logic [31:0] xb, yb;

  // returns {lo, hi}
  function automatic logic [31:0] bounds(input logic [15:0] pos, input logic [15:0] len,
                                          input logic ctr);
    logic [15:0] half;
    logic [15:0] lo;
    logic [15:0] hi;
    half = {1'b0, len[15:1]};
    if (ctr) begin
      lo = pos - half;
      hi = pos + half - {15'd0, ~len[0]};
    end else begin
      lo = pos;
      hi = pos + len - 16'd1;
    end
    return {lo, hi};
  endfunction

  assign in_ch.ready = q_ready_i;
  assign accept      = in_ch.valid && q_ready_i;

  assign xb = bounds(in_ch.x_pos, in_ch.win_width, in_ch.centred);
  assign yb = bounds(in_ch.y_pos, in_ch.win_height, in_ch.centred);

  assign has_room = (width_q != 16'd0) && (row_q < height_q);
  assign remain   = width_q - col_q;
  assign count    = (remain < 16'(bwlcd_pkg::PIXELS_PER_BYTE)) ? remain[3:0]
                                                              : 4'(bwlcd_pkg::PIXELS_PER_BYTE);
  assign col_sum  = col_q + {12'd0, count};

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    row_d    = row_q;
    col_d    = col_q;
    fore_d   = fore_q;
    back_d   = back_q;
    push_o   = 1'b0;

    job_o.is_window = 1'b0;
    job_o.x0        = xb[31:16];
    job_o.x1        = xb[15:0];
    job_o.y0        = yb[31:16];
    job_o.y1        = yb[15:0];
    job_o.fore      = fore_q;
    job_o.back      = back_q;
    job_o.bits      = (in_ch.kind == bwlcd_pkg::KIND_SOLID) ? bwlcd_pkg::SOLID_BITS
                                                           : in_ch.bitmap_byte;
    job_o.cnt_m1    = 3'(count - 4'd1);

    if (accept) begin
      unique case (in_ch.kind)
        bwlcd_pkg::KIND_OPEN: begin
          push_o          = 1'b1;
          job_o.is_window = 1'b1;
          width_d         = in_ch.win_width;
          height_d        = in_ch.win_height;
          row_d           = 16'd0;
          col_d           = 16'd0;
          fore_d          = in_ch.fore_colour;
          back_d          = in_ch.back_colour;
        end
        bwlcd_pkg::KIND_BITMAP, bwlcd_pkg::KIND_SOLID: begin
          if (has_room) begin
            push_o = 1'b1;
            if (col_sum >= width_q) begin
              col_d = 16'd0;
              row_d = row_q + 16'd1;
            end else begin
              col_d = col_sum;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= '0;
      height_q <= '0;
      row_q    <= '0;
      col_q    <= '0;
      fore_q   <= '0;
      back_q   <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      row_q    <= row_d;
      col_q    <= col_d;
      fore_q   <= fore_d;
      back_q   <= back_d;
    end
  end

endmodule

/* src/bwlcd_queue.sv */
// short job queue between the front end and the bus sequencer
// depends on bwlcd_pkg
module bwlcd_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  bwlcd_pkg::job_t  job_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic             valid_o,
  output bwlcd_pkg::job_t  job_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  bwlcd_pkg::job_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign ready_o = (cnt_q != CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* src/bwlcd_back.sv */
// bus sequencer: expands each job into bus bytes, one per cycle unless out_ch stalls, into an output register
// depends on bwlcd_pkg and bwlcd_out_if
module bwlcd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bwlcd_pkg::cfg_t  cfg_i,
  input  logic             q_valid_i,
  input  bwlcd_pkg::job_t  q_job_i,
  output logic             pop_o,
  bwlcd_out_if.source      out_ch
);

  logic            active_q;
  logic [3:0]      step_q;
  bwlcd_pkg::job_t job_q;
  logic [7:0]      bits_q;

  logic            ovalid_q;
  logic            ocmd_q;
  logic [7:0]      obyte_q;
  logic            oeos_q;
  logic            olast_q;

  logic            can_emit, emit, last_step, load;
  logic            cmd_c, eos_c;
  logic [7:0]      byte_c;
  logic [15:0]     word_c;

  assign can_emit = !ovalid_q || out_ch.ready;
  assign emit     = active_q && can_emit;
  assign word_c   = bits_q[7] ? job_q.fore : job_q.back;

  always_comb begin
    cmd_c     = 1'b0;
    eos_c     = 1'b0;
    byte_c    = 8'd0;
    last_step = 1'b0;
    if (job_q.is_window) begin
      last_step = (step_q == bwlcd_pkg::STEP_MEM_CMD);
      unique case (step_q)
        bwlcd_pkg::STEP_COL_CMD: begin
          cmd_c = 1'b1; eos_c = 1'b1; byte_c = cfg_i.col_cmd;
        end
        bwlcd_pkg::STEP_X0_HI: byte_c = job_q.x0[15:8];
        bwlcd_pkg::STEP_X0_LO: begin
          eos_c = 1'b1; byte_c = job_q.x0[7:0];
        end
        bwlcd_pkg::STEP_X1_HI: byte_c = job_q.x1[15:8];
        bwlcd_pkg::STEP_X1_LO: begin
          eos_c = 1'b1; byte_c = job_q.x1[7:0];
        end
        bwlcd_pkg::STEP_PAGE_CMD: begin
          cmd_c = 1'b1; eos_c = 1'b1; byte_c = cfg_i.page_cmd;
        end
        bwlcd_pkg::STEP_Y0_HI: byte_c = job_q.y0[15:8];
        bwlcd_pkg::STEP_Y0_LO: begin
          eos_c = 1'b1; byte_c = job_q.y0[7:0];
        end
        bwlcd_pkg::STEP_Y1_HI: byte_c = job_q.y1[15:8];
        bwlcd_pkg::STEP_Y1_LO: begin
          eos_c = 1'b1; byte_c = job_q.y1[7:0];
        end
        bwlcd_pkg::STEP_MEM_CMD: begin
          cmd_c = 1'b1; eos_c = 1'b1; byte_c = cfg_i.mem_cmd;
        end
        default: begin
        end
      endcase
    end else begin
      // two bytes per pixel, high byte first
      eos_c     = step_q[0];
      byte_c    = step_q[0] ? word_c[7:0] : word_c[15:8];
      last_step = (step_q == {job_q.cnt_m1, 1'b1});
    end
  end

  // take the next job as the current one sends its final byte
  assign load  = q_valid_i && (!active_q || (emit && last_step));
  assign pop_o = load;

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q  <= q_job_i;
      bits_q <= q_job_i.bits;
    end else if (emit && step_q[0] && !job_q.is_window) begin
      bits_q <= {bits_q[6:0], 1'b0};
    end
    if (emit) begin
      ocmd_q  <= cmd_c;
      obyte_q <= byte_c;
      oeos_q  <= eos_c;
      olast_q <= last_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      step_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (load) begin
        active_q <= 1'b1;
        step_q   <= '0;
      end else if (emit && last_step) begin
        active_q <= 1'b0;
      end else if (emit) begin
        step_q <= step_q + 4'd1;
      end
      if (emit) begin
        ovalid_q <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign out_ch.valid         = ovalid_q;
  assign out_ch.is_command    = ocmd_q;
  assign out_ch.bus_byte      = obyte_q;
  assign out_ch.end_of_select = oeos_q;
  assign out_ch.last          = olast_q;

endmodule
